// ----- hw/rtl/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared codes and types of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int PAGE_W     = 12;
	localparam int ORDER_W    = 4;
	localparam int PAGE_COUNT = 1 << PAGE_W;

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_SEED  = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_NOMEM = 3'd1,
		ST_ORDER = 3'd2,
		ST_REFD  = 3'd3,
		ST_BAD   = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_RESP,
		S_FR_CHK,
		S_SD_CHK,
		S_M_TOP,
		S_M_CHK,
		S_M_NEXT,
		S_U_RD,
		S_U_DAT,
		S_U_P,
		S_U_N1,
		S_U_N2,
		S_P_RD,
		S_P_WR,
		S_P_H1,
		S_P_H2,
		S_A_SPLIT
	} state_t;

	// per-page record
	typedef struct packed {
		logic [ORDER_W-1:0] order;
		logic               free;
		logic               start;
	} info_t;

endpackage

// ----- hw/rtl/buddy_page_allocator.sv -----
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Binary buddy page allocator, one LIFO free list per order; list links and
// page records kept in two on-chip RAMs, list heads in registers.
// ----------------------------------------------------------------------------
//  channel | signals                                      | dir
//  req     | req_valid/req_ready, action, req_order,       | in
//          | page_index, still_referenced                  |
//  rsp     | rsp_valid/rsp_ready, status, block_page,      | out
//          | block_order                                   |
//
// One request at a time; list unlinks and pushes are paced by the single read
// port of the link RAM. After reset the page record RAM is cleared, one entry
// a cycle, with req_ready low. A held result does not block the next request.
// ----------------------------------------------------------------------------
module buddy_page_allocator #(
	parameter int TOP_ORDER  = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [1:0]                   action,
	input  logic [bpa_pkg::ORDER_W-1:0]  req_order,
	input  logic [bpa_pkg::PAGE_W-1:0]   page_index,
	input  logic                         still_referenced,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic [2:0]                   status,
	output logic [bpa_pkg::PAGE_W-1:0]   block_page,
	output logic [bpa_pkg::ORDER_W-1:0]  block_order
);

	localparam int PAGE_COUNT = bpa_pkg::PAGE_COUNT;
	localparam int OW = bpa_pkg::ORDER_W;
	localparam int PW = $clog2(PAGE_COUNT);
	localparam int LW = $clog2(PAGE_COUNT + 1);
	localparam int EW = ((LW > 16) ? LW : 16) + 1;
	localparam int HW = (TOP_ORDER > 1) ? $clog2(TOP_ORDER + 1) : 1;
	localparam int NL = TOP_ORDER + 1;
	localparam logic [LW-1:0] NIL = LW'(PAGE_COUNT);
	localparam logic [OW-1:0] TOP = OW'(TOP_ORDER);
	localparam int IW = $bits(bpa_pkg::info_t);

	bpa_pkg::state_t state_q, state_d;

	logic [LW-1:0] head_q [NL];
	logic [LW-1:0] head_d [NL];

	logic [LW-1:0] pg_q, pg_d, bud_q, bud_d, op_pg_q, op_pg_d;
	logic [LW-1:0] n_q, n_d, p_q, p_d, h_q, h_d;
	logic [OW-1:0] ord_q, ord_d, req_q, req_d, op_ord_q, op_ord_d;
	logic          alloc_q, alloc_d;
	logic [PW-1:0] clr_q, clr_d;

	bpa_pkg::status_t res_status_q, res_status_d;
	logic [LW-1:0] res_page_q, res_page_d;
	logic [OW-1:0] res_order_q, res_order_d;

	logic                  rsp_valid_q, rsp_valid_d;
	bpa_pkg::status_t      status_q, status_d;
	logic [bpa_pkg::PAGE_W-1:0] block_page_q, block_page_d;
	logic [OW-1:0]         block_order_q, block_order_d;

	// RAM ports
	logic            link_we;
	logic [PW-1:0]   link_waddr, link_raddr;
	logic [2*LW-1:0] link_wdata, link_rdata;
	logic            info_we;
	logic [PW-1:0]   info_waddr, info_raddr;
	bpa_pkg::info_t  info_wdata, info_rdata;
	logic [IW-1:0]   info_rraw;

	logic [LW-1:0] lr_next, lr_prev;
	assign lr_next   = link_rdata[2*LW-1:LW];
	assign lr_prev   = link_rdata[LW-1:0];
	assign info_rdata = bpa_pkg::info_t'(info_rraw);

	bpa_ram #(.WIDTH(2*LW), .DEPTH(PAGE_COUNT)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	bpa_ram #(.WIDTH(IW), .DEPTH(PAGE_COUNT)) u_info_ram (
		.clk   (clk),
		.we    (info_we),
		.waddr (info_waddr),
		.wdata (IW'(info_wdata)),
		.raddr (info_raddr),
		.rdata (info_rraw)
	);

	// lowest non-empty list at or above the requested order
	logic          found;
	logic [OW-1:0] found_ord;
	always_comb begin
		found     = 1'b0;
		found_ord = '0;
		for (int i = 0; i < NL; i++) begin
			if (!found && (OW'(i) >= req_order) && (head_q[i] != NIL)) begin
				found     = 1'b1;
				found_ord = OW'(i);
			end
		end
	end

	logic [EW-1:0] pi_e, size_e, bud_e, half_e;
	logic [OW-1:0] ord_m1;
	assign pi_e   = EW'(page_index);
	assign size_e = EW'(1) << req_order;
	assign bud_e  = EW'(pg_q) ^ (EW'(1) << ord_q);
	assign ord_m1 = ord_q - OW'(1);
	assign half_e = EW'(pg_q) + (EW'(1) << ord_m1);

	always_comb begin
		state_d       = state_q;
		head_d        = head_q;
		pg_d          = pg_q;
		bud_d         = bud_q;
		op_pg_d       = op_pg_q;
		n_d           = n_q;
		p_d           = p_q;
		h_d           = h_q;
		ord_d         = ord_q;
		req_d         = req_q;
		op_ord_d      = op_ord_q;
		alloc_d       = alloc_q;
		clr_d         = clr_q;
		res_status_d  = res_status_q;
		res_page_d    = res_page_q;
		res_order_d   = res_order_q;
		rsp_valid_d   = rsp_valid_q;
		status_d      = status_q;
		block_page_d  = block_page_q;
		block_order_d = block_order_q;

		req_ready  = 1'b0;
		link_we    = 1'b0;
		link_waddr = op_pg_q[PW-1:0];
		link_wdata = {n_q, p_q};
		link_raddr = op_pg_q[PW-1:0];
		info_we    = 1'b0;
		info_waddr = op_pg_q[PW-1:0];
		info_wdata = info_rdata;
		info_raddr = op_pg_q[PW-1:0];

		if (rsp_valid_q && rsp_ready) begin
			rsp_valid_d = 1'b0;
		end

		case (state_q)
			bpa_pkg::S_CLR: begin
				info_we    = 1'b1;
				info_waddr = clr_q;
				info_wdata = '0;
				clr_d      = clr_q + PW'(1);
				if (clr_q == PW'(PAGE_COUNT - 1)) begin
					state_d = bpa_pkg::S_IDLE;
				end
			end
			bpa_pkg::S_IDLE: begin
				req_ready   = 1'b1;
				res_page_d  = '0;
				res_order_d = '0;
				pg_d        = LW'(page_index);
				ord_d       = req_order;
				req_d       = req_order;
				info_raddr  = page_index[PW-1:0];
				if (req_valid) begin
					state_d = bpa_pkg::S_RESP;
					case (action)
						bpa_pkg::ACT_ALLOC: begin
							if (req_order > TOP) begin
								res_status_d = bpa_pkg::ST_ORDER;
							end else if (!found) begin
								res_status_d = bpa_pkg::ST_NOMEM;
							end else begin
								pg_d     = head_q[found_ord[HW-1:0]];
								op_pg_d  = head_q[found_ord[HW-1:0]];
								ord_d    = found_ord;
								op_ord_d = found_ord;
								alloc_d  = 1'b1;
								state_d  = bpa_pkg::S_U_RD;
							end
						end
						bpa_pkg::ACT_FREE: begin
							if (still_referenced) begin
								res_status_d = bpa_pkg::ST_REFD;
							end else if (pi_e >= EW'(PAGE_COUNT)) begin
								res_status_d = bpa_pkg::ST_BAD;
							end else begin
								alloc_d = 1'b0;
								state_d = bpa_pkg::S_FR_CHK;
							end
						end
						bpa_pkg::ACT_SEED: begin
							if (req_order > TOP) begin
								res_status_d = bpa_pkg::ST_ORDER;
							end else if (((pi_e & (size_e - EW'(1))) != '0) ||
									(pi_e + size_e > EW'(PAGE_COUNT))) begin
								res_status_d = bpa_pkg::ST_BAD;
							end else begin
								alloc_d = 1'b0;
								state_d = bpa_pkg::S_SD_CHK;
							end
						end
						default: begin
							res_status_d = bpa_pkg::ST_BAD;
						end
					endcase
				end
			end
			bpa_pkg::S_FR_CHK: begin
				if (!info_rdata.start) begin
					res_status_d = bpa_pkg::ST_BAD;
					state_d      = bpa_pkg::S_RESP;
				end else begin
					info_we          = 1'b1;
					info_waddr       = pg_q[PW-1:0];
					info_wdata.start = 1'b0;
					ord_d   = (info_rdata.order > TOP) ? TOP : info_rdata.order;
					state_d = bpa_pkg::S_M_TOP;
				end
			end
			bpa_pkg::S_SD_CHK: begin
				if (info_rdata.free || info_rdata.start) begin
					res_status_d = bpa_pkg::ST_BAD;
					state_d      = bpa_pkg::S_RESP;
				end else begin
					info_we          = 1'b1;
					info_waddr       = pg_q[PW-1:0];
					info_wdata.order = ord_q;
					state_d          = bpa_pkg::S_M_TOP;
				end
			end
			bpa_pkg::S_M_TOP: begin
				op_pg_d  = pg_q;
				op_ord_d = ord_q;
				bud_d    = bud_e[LW-1:0];
				info_raddr = bud_e[PW-1:0];
				if (ord_q < TOP && bud_e < EW'(PAGE_COUNT)) begin
					state_d = bpa_pkg::S_M_CHK;
				end else begin
					state_d = bpa_pkg::S_P_RD;
				end
			end
			bpa_pkg::S_M_CHK: begin
				if (info_rdata.free && info_rdata.order == ord_q) begin
					op_pg_d = bud_q;
					state_d = bpa_pkg::S_U_RD;
				end else begin
					state_d = bpa_pkg::S_P_RD;
				end
			end
			bpa_pkg::S_M_NEXT: begin
				if (bud_q < pg_q) begin
					pg_d = bud_q;
				end
				ord_d   = ord_q + OW'(1);
				state_d = bpa_pkg::S_M_TOP;
			end
			// unlink op_pg from list op_ord
			bpa_pkg::S_U_RD: begin
				state_d = bpa_pkg::S_U_DAT;
			end
			bpa_pkg::S_U_DAT: begin
				n_d             = lr_next;
				p_d             = lr_prev;
				info_we         = 1'b1;
				info_wdata.free = 1'b0;
				link_raddr      = lr_prev[PW-1:0];
				if (lr_prev < NIL) begin
					state_d = bpa_pkg::S_U_P;
				end else begin
					if (head_q[op_ord_q[HW-1:0]] == op_pg_q) begin
						head_d[op_ord_q[HW-1:0]] = lr_next;
					end
					state_d = bpa_pkg::S_U_N1;
				end
			end
			bpa_pkg::S_U_P: begin
				link_we    = 1'b1;
				link_waddr = p_q[PW-1:0];
				link_wdata = {n_q, lr_prev};
				state_d    = bpa_pkg::S_U_N1;
			end
			bpa_pkg::S_U_N1: begin
				link_raddr = n_q[PW-1:0];
				if (n_q < NIL) begin
					state_d = bpa_pkg::S_U_N2;
				end else begin
					state_d = alloc_q ? bpa_pkg::S_A_SPLIT : bpa_pkg::S_M_NEXT;
				end
			end
			bpa_pkg::S_U_N2: begin
				link_we    = 1'b1;
				link_waddr = n_q[PW-1:0];
				link_wdata = {lr_next, p_q};
				state_d    = alloc_q ? bpa_pkg::S_A_SPLIT : bpa_pkg::S_M_NEXT;
			end
			// push op_pg onto list op_ord
			bpa_pkg::S_P_RD: begin
				state_d = bpa_pkg::S_P_WR;
			end
			bpa_pkg::S_P_WR: begin
				h_d              = head_q[op_ord_q[HW-1:0]];
				link_we          = 1'b1;
				link_wdata       = {head_q[op_ord_q[HW-1:0]], NIL};
				info_we          = 1'b1;
				info_wdata.order = op_ord_q;
				info_wdata.free  = 1'b1;
				head_d[op_ord_q[HW-1:0]] = op_pg_q;
				if (head_q[op_ord_q[HW-1:0]] < NIL) begin
					state_d = bpa_pkg::S_P_H1;
				end else if (alloc_q) begin
					state_d = bpa_pkg::S_A_SPLIT;
				end else begin
					res_status_d = bpa_pkg::ST_OK;
					res_page_d   = pg_q;
					res_order_d  = ord_q;
					state_d      = bpa_pkg::S_RESP;
				end
			end
			bpa_pkg::S_P_H1: begin
				link_raddr = h_q[PW-1:0];
				state_d    = bpa_pkg::S_P_H2;
			end
			bpa_pkg::S_P_H2: begin
				link_we    = 1'b1;
				link_waddr = h_q[PW-1:0];
				link_wdata = {lr_next, op_pg_q};
				if (alloc_q) begin
					state_d = bpa_pkg::S_A_SPLIT;
				end else begin
					res_status_d = bpa_pkg::ST_OK;
					res_page_d   = pg_q;
					res_order_d  = ord_q;
					state_d      = bpa_pkg::S_RESP;
				end
			end
			bpa_pkg::S_A_SPLIT: begin
				if (ord_q > req_q) begin
					ord_d    = ord_m1;
					op_ord_d = ord_m1;
					op_pg_d  = half_e[LW-1:0];
					if (half_e < EW'(PAGE_COUNT)) begin
						state_d = bpa_pkg::S_P_RD;
					end
				end else begin
					info_we    = 1'b1;
					info_waddr = pg_q[PW-1:0];
					info_wdata = '{order: req_q, free: 1'b0, start: 1'b1};
					res_status_d = bpa_pkg::ST_OK;
					res_page_d   = pg_q;
					res_order_d  = req_q;
					state_d      = bpa_pkg::S_RESP;
				end
			end
			bpa_pkg::S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_valid_d   = 1'b1;
					status_d      = res_status_q;
					block_page_d  = (res_status_q == bpa_pkg::ST_OK) ?
						res_page_q[bpa_pkg::PAGE_W-1:0] : '0;
					block_order_d = (res_status_q == bpa_pkg::ST_OK) ? res_order_q : '0;
					state_d       = bpa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= bpa_pkg::S_CLR;
			for (int i = 0; i < NL; i++) begin
				head_q[i] <= NIL;
			end
			pg_q          <= '0;
			bud_q         <= '0;
			op_pg_q       <= '0;
			n_q           <= '0;
			p_q           <= '0;
			h_q           <= '0;
			ord_q         <= '0;
			req_q         <= '0;
			op_ord_q      <= '0;
			alloc_q       <= 1'b0;
			clr_q         <= '0;
			res_status_q  <= bpa_pkg::ST_OK;
			res_page_q    <= '0;
			res_order_q   <= '0;
			rsp_valid_q   <= 1'b0;
			status_q      <= bpa_pkg::ST_OK;
			block_page_q  <= '0;
			block_order_q <= '0;
		end else begin
			state_q       <= state_d;
			head_q        <= head_d;
			pg_q          <= pg_d;
			bud_q         <= bud_d;
			op_pg_q       <= op_pg_d;
			n_q           <= n_d;
			p_q           <= p_d;
			h_q           <= h_d;
			ord_q         <= ord_d;
			req_q         <= req_d;
			op_ord_q      <= op_ord_d;
			alloc_q       <= alloc_d;
			clr_q         <= clr_d;
			res_status_q  <= res_status_d;
			res_page_q    <= res_page_d;
			res_order_q   <= res_order_d;
			rsp_valid_q   <= rsp_valid_d;
			status_q      <= status_d;
			block_page_q  <= block_page_d;
			block_order_q <= block_order_d;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign block_page  = block_page_q;
	assign block_order = block_order_q;

endmodule

// ----- hw/rtl/bpa_ram.sv -----
// ----------------------------------------------------------------------------
// bpa_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/bpa_checker.sv -----
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks of the buddy page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpa_checker #(
	parameter int TOP_ORDER = 10
) (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  status,
	input logic [11:0] block_page,
	input logic [3:0]  block_order
);

	// a held result keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
		$stable(block_page) && $stable(block_order))
		else $error("result changed while stalled");

	// refused requests carry no block
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != 3'd0 |-> block_page == '0 && block_order == '0)
		else $error("error result with nonzero block");

	// granted orders stay within the list range
	a_order_rng: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> block_order <= 4'(TOP_ORDER))
		else $error("block order out of range");

	// one request in work at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

endmodule

bind buddy_page_allocator bpa_checker #(.TOP_ORDER(TOP_ORDER)) u_bpa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_ready   (req_ready),
	.rsp_valid   (rsp_valid),
	.rsp_ready   (rsp_ready),
	.status      (status),
	.block_page  (block_page),
	.block_order (block_order)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for buddy_page_allocator. A directed table covers the
// refusal codes, seeding and merging up to the top order, split on allocate,
// double and stray frees. It is followed by random allocate/free/seed traffic
// that mostly frees blocks actually held. Every request runs through a local
// allocator model, and each response is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          TOP      = 10;
	localparam int          PAGES    = 4096;
	localparam logic [12:0] NIL      = 13'(PAGES);
	localparam logic [1:0]  ACT_NONE = 2'd3;
	localparam int          N_DIR    = 26;
	localparam int          N_RAND   = 800;
	localparam int          LIMIT    = 2000000;

	typedef struct packed {
		logic [2:0]  st;
		logic [11:0] pg;
		logic [3:0]  ord;
	} alloc_rsp_t;

	typedef struct {
		logic [1:0]  act;
		logic [3:0]  ord;
		logic [11:0] pg;
		logic        refd;
		bit          typed;
		alloc_rsp_t  exp;
	} dir_row_t;

	typedef struct {
		logic [11:0] pg;
		logic [3:0]  ord;
	} held_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        req_valid = 0;
	logic        req_ready;
	logic [1:0]  action = '0;
	logic [3:0]  req_order = '0;
	logic [11:0] page_index = '0;
	logic        still_referenced = 0;
	logic        rsp_valid;
	logic        rsp_ready = 0;
	logic [2:0]  status;
	logic [11:0] block_page;
	logic [3:0]  block_order;

	buddy_page_allocator u_dut (.*);

	// allocator model
	logic [12:0] nxt [PAGES];
	logic [12:0] prv [PAGES];
	logic [3:0]  pord [PAGES];
	bit          fmark [PAGES];
	bit          smark [PAGES];
	logic [12:0] head [TOP+1];
	logic [12:0] cnt [TOP+1];

	dir_row_t   dir_tab [N_DIR];
	alloc_rsp_t rsp_q [$];
	held_t      held_q [$];
	bit         typed_q [$];
	alloc_rsp_t typed_exp_q [$];

	int n_sent, n_acc, n_rsp, n_err, cyc, gap_req, gap_rsp;
	int cnt_ok, cnt_bad;
	bit all_sent;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void push_free(logic [12:0] p, logic [3:0] o);
		logic [12:0] h;
		h = head[o];
		nxt[p] = h;
		prv[p] = NIL;
		if (h < NIL)
			prv[h] = p;
		head[o] = p;
		cnt[o] = cnt[o] + 1;
		pord[p] = o;
		fmark[p] = 1;
	endfunction

	function automatic void unlink_free(logic [12:0] p, logic [3:0] o);
		logic [12:0] n, q;
		n = nxt[p];
		q = prv[p];
		if (q < NIL)
			nxt[q] = n;
		else if (head[o] == p)
			head[o] = n;
		if (n < NIL)
			prv[n] = q;
		cnt[o] = cnt[o] - 1;
		fmark[p] = 0;
	endfunction

	function automatic alloc_rsp_t coalesce(logic [12:0] p);
		logic [12:0] bud;
		int o;
		alloc_rsp_t r;
		o = pord[p];
		if (o > TOP)
			o = TOP;
		while (o < TOP) begin
			bud = p ^ (13'd1 << o);
			if (bud >= NIL || !fmark[bud] || pord[bud] != 4'(o))
				break;
			unlink_free(bud, 4'(o));
			if (bud < p)
				p = bud;
			o++;
		end
		push_free(p, 4'(o));
		r.st = bpa_pkg::ST_OK;
		r.pg = p[11:0];
		r.ord = 4'(o);
		return r;
	endfunction

	function automatic alloc_rsp_t predict_alloc(logic [1:0] act, logic [3:0] ord,
			logic [11:0] pg, logic refd);
		alloc_rsp_t r;
		int c;
		logic [12:0] blk, half;
		r = '{st: bpa_pkg::ST_OK, pg: '0, ord: '0};
		case (act)
			bpa_pkg::ACT_ALLOC: begin
				if (ord > TOP) begin
					r.st = bpa_pkg::ST_ORDER;
				end else begin
					c = ord;
					while (c <= TOP && head[c] >= NIL)
						c++;
					if (c > TOP) begin
						r.st = bpa_pkg::ST_NOMEM;
					end else begin
						blk = head[c];
						unlink_free(blk, 4'(c));
						while (c > ord) begin
							c--;
							half = blk + (13'd1 << c);
							if (half < NIL)
								push_free(half, 4'(c));
						end
						pord[blk] = ord;
						smark[blk] = 1;
						r.pg = blk[11:0];
						r.ord = ord;
					end
				end
			end
			bpa_pkg::ACT_FREE: begin
				if (refd) begin
					r.st = bpa_pkg::ST_REFD;
				end else if (!smark[pg]) begin
					r.st = bpa_pkg::ST_BAD;
				end else begin
					smark[pg] = 0;
					r = coalesce({1'b0, pg});
				end
			end
			bpa_pkg::ACT_SEED: begin
				if (ord > TOP)
					r.st = bpa_pkg::ST_ORDER;
				else if ((pg & ((12'd1 << ord) - 12'd1)) != 0 ||
						int'(pg) + (1 << ord) > PAGES || fmark[pg] || smark[pg])
					r.st = bpa_pkg::ST_BAD;
				else begin
					pord[pg] = ord;
					r = coalesce({1'b0, pg});
				end
			end
			default: r.st = bpa_pkg::ST_BAD;
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int d;
		d = $urandom_range(0, 99);
		if (d < 65)
			return 0;
		if (d < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [3:0] pick_order();
		int d;
		d = $urandom_range(0, 99);
		if (d < 60)
			return 4'($urandom_range(0, 3));
		if (d < 95)
			return 4'($urandom_range(4, TOP));
		return 4'($urandom_range(TOP + 1, 15));
	endfunction

	// random request: mostly frees of held blocks and allocates, some seeds,
	// the rest noise (stray, tail, referenced, unknown action)
	task automatic make_random(output logic [1:0] a, output logic [3:0] o,
			output logic [11:0] p, output logic r);
		int d, k;
		d = $urandom_range(0, 99);
		a = bpa_pkg::ACT_ALLOC;
		o = pick_order();
		p = 12'($urandom);
		r = 0;
		if (d < 38) begin
			a = bpa_pkg::ACT_ALLOC;
		end else if (d < 72 && held_q.size() > 0) begin
			k = $urandom_range(0, held_q.size() - 1);
			a = bpa_pkg::ACT_FREE;
			p = held_q[k].pg;
		end else if (d < 84) begin
			a = bpa_pkg::ACT_SEED;
			if ($urandom_range(0, 9) != 0 && o <= TOP)
				p = p & ~((12'd1 << o) - 12'd1);
		end else if (d < 88 && held_q.size() > 0) begin
			k = $urandom_range(0, held_q.size() - 1);
			a = bpa_pkg::ACT_FREE;
			p = held_q[k].pg + ((held_q[k].ord > 0) ? 12'd1 : 12'd0);
		end else if (d < 92) begin
			a = bpa_pkg::ACT_FREE;
			r = 1;
		end else if (d < 96) begin
			a = bpa_pkg::ACT_FREE;
		end else begin
			a = 2'($urandom_range(0, 3));
			r = 1'($urandom);
		end
	endtask

	task automatic report(string what, int got, int want);
		$display("MISMATCH %s: got %0d want %0d (response %0d)", what, got, want, n_rsp);
		n_err++;
	endtask

	// request side: predict at each transfer, then load the next request
	always @(posedge clk) begin
		logic [1:0] a;
		logic [3:0] o;
		logic [11:0] p;
		logic r;
		alloc_rsp_t e;
		int k;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				e = predict_alloc(action, req_order, page_index, still_referenced);
				rsp_q.push_back(e);
				typed_q.push_back(n_acc < N_DIR && dir_tab[n_acc].typed);
				if (n_acc < N_DIR)
					typed_exp_q.push_back(dir_tab[n_acc].exp);
				else
					typed_exp_q.push_back(e);
				if (e.st == bpa_pkg::ST_OK && action == bpa_pkg::ACT_ALLOC)
					held_q.push_back('{pg: e.pg, ord: req_order});
				if (e.st == bpa_pkg::ST_OK && action == bpa_pkg::ACT_FREE)
					for (k = 0; k < held_q.size(); k++)
						if (held_q[k].pg == page_index) begin
							held_q.delete(k);
							break;
						end
				n_acc++;
			end
			if (!req_valid || req_ready) begin
				if (n_sent >= N_DIR + N_RAND) begin
					req_valid <= 0;
					all_sent = 1;
				end else if (gap_req > 0) begin
					gap_req--;
					req_valid <= 0;
				end else begin
					if (n_sent < N_DIR) begin
						a = dir_tab[n_sent].act;
						o = dir_tab[n_sent].ord;
						p = dir_tab[n_sent].pg;
						r = dir_tab[n_sent].refd;
					end else
						make_random(a, o, p, r);
					req_valid <= 1;
					action <= a;
					req_order <= o;
					page_index <= p;
					still_referenced <= r;
					n_sent++;
					// back-to-back window with no idling
					gap_req = (n_sent > 300 && n_sent < 400) ? 0 : pick_gap();
				end
			end
		end
	end

	// response side: check each transfer, stall at random
	always @(posedge clk) begin
		alloc_rsp_t e, t;
		bit ty;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (rsp_q.size() == 0) begin
					report("unexpected response", status, -1);
				end else begin
					e = rsp_q.pop_front();
					ty = typed_q.pop_front();
					t = typed_exp_q.pop_front();
					if (ty && t != e)
						report("table entry disagrees with model", e, t);
					if (status != e.st)
						report("status", status, e.st);
					if (block_page != e.pg)
						report("block_page", block_page, e.pg);
					if (block_order != e.ord)
						report("block_order", block_order, e.ord);
					if (e.st == bpa_pkg::ST_OK)
						cnt_ok++;
					else
						cnt_bad++;
				end
				n_rsp++;
			end
			if (n_rsp > 300 && n_rsp < 400) begin
				rsp_ready <= 1;
			end else if (gap_rsp > 0) begin
				gap_rsp--;
				rsp_ready <= 0;
			end else begin
				rsp_ready <= 1;
				gap_rsp = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > LIMIT) begin
			$display("timeout after %0d cycles", cyc);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic dir_row_t row(logic [1:0] a, logic [3:0] o, logic [11:0] p,
			logic r, bit ty = 0, logic [2:0] s = bpa_pkg::ST_OK, logic [11:0] ep = 0,
			logic [3:0] eo = 0);
		dir_row_t d;
		d.act = a;
		d.ord = o;
		d.pg = p;
		d.refd = r;
		d.typed = ty;
		d.exp = '{st: s, pg: ep, ord: eo};
		return d;
	endfunction

	initial begin
		int i;
		for (i = 0; i < PAGES; i++) begin
			nxt[i] = '0;
			prv[i] = '0;
			pord[i] = '0;
			fmark[i] = 0;
			smark[i] = 0;
		end
		for (i = 0; i <= TOP; i++) begin
			head[i] = NIL;
			cnt[i] = '0;
		end
		dir_tab[0]  = row(bpa_pkg::ACT_ALLOC, 0, 0, 0, 1, bpa_pkg::ST_NOMEM);
		dir_tab[1]  = row(bpa_pkg::ACT_ALLOC, 11, 0, 0, 1, bpa_pkg::ST_ORDER);
		dir_tab[2]  = row(bpa_pkg::ACT_ALLOC, 15, 12'hFFF, 1, 1, bpa_pkg::ST_ORDER);
		dir_tab[3]  = row(bpa_pkg::ACT_SEED, 15, 0, 0, 1, bpa_pkg::ST_ORDER);
		dir_tab[4]  = row(bpa_pkg::ACT_FREE, 0, 5, 1, 1, bpa_pkg::ST_REFD);
		dir_tab[5]  = row(bpa_pkg::ACT_FREE, 15, 12'hFFF, 0, 1, bpa_pkg::ST_BAD);
		dir_tab[6]  = row(ACT_NONE, 0, 0, 0, 1, bpa_pkg::ST_BAD);
		dir_tab[7]  = row(bpa_pkg::ACT_SEED, 3, 4, 0, 1, bpa_pkg::ST_BAD);
		dir_tab[8]  = row(bpa_pkg::ACT_SEED, 10, 3072, 1, 1, bpa_pkg::ST_OK, 3072, 10);
		dir_tab[9]  = row(bpa_pkg::ACT_SEED, 10, 3072, 0, 1, bpa_pkg::ST_BAD);
		dir_tab[10] = row(bpa_pkg::ACT_SEED, 0, 0, 0, 1, bpa_pkg::ST_OK, 0, 0);
		dir_tab[11] = row(bpa_pkg::ACT_SEED, 0, 1, 0, 1, bpa_pkg::ST_OK, 0, 1);
		// climb the lower quarter back to one top-order block
		for (i = 1; i < TOP; i++)
			dir_tab[11 + i] = row(bpa_pkg::ACT_SEED, 4'(i), 12'(1 << i), 0);
		dir_tab[21] = row(bpa_pkg::ACT_ALLOC, 10, 0, 0, 1, bpa_pkg::ST_OK, 0, 10);
		dir_tab[22] = row(bpa_pkg::ACT_ALLOC, 0, 0, 0);
		dir_tab[23] = row(bpa_pkg::ACT_FREE, 0, 3072, 0);
		dir_tab[24] = row(bpa_pkg::ACT_FREE, 0, 3072, 0, 1, bpa_pkg::ST_BAD);
		dir_tab[25] = row(bpa_pkg::ACT_FREE, 0, 0, 0, 1, bpa_pkg::ST_OK, 0, 10);
		repeat (10) @(posedge clk);
		arst_n <= 1;
		wait (all_sent && rsp_q.size() == 0);
		repeat (200) @(posedge clk);
		$display("%0d requests issued, %0d granted or merged, %0d refused", n_acc, cnt_ok,
			cnt_bad);
		$display("blocks still held at the end: %0d", held_q.size());
		if (n_err == 0 && rsp_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
